>>> hdl/fnvlp_pkg.sv
// ----------------------------------------------------------------------------
// fnvlp_pkg
// Types and constants shared by the FNV-1a linear probe key table.
// ----------------------------------------------------------------------------
package fnvlp_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_REPLACED  = 3'd4;

  typedef struct packed {
    logic        action;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [15:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_value;
    logic [5:0]  slot_index;
    logic [6:0]  entry_total;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_DONE
  } bk_state_t;

endpackage

>>> hdl/fnvlp_front.sv
// ----------------------------------------------------------------------------
// fnvlp_front
// Hashes key bytes and buffers the key; hands a finished key to the queue.
// ----------------------------------------------------------------------------
module fnvlp_front import fnvlp_pkg::*; #(
  parameter int KEY_BYTES  = 32,
  parameter int VALUE_BITS = 16,
  localparam int KW = (KEY_BYTES + 7) / 8,
  localparam int LW = $clog2(KEY_BYTES + 2)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  in_item_t              in_item,
  output logic                  in_ready,
  output logic                  q_push,
  input  logic                  q_full,
  output logic [31:0]           q_hash,
  output logic [KW*64-1:0]      q_key,
  output logic                  q_too_long,
  output logic                  q_action,
  output logic [VALUE_BITS-1:0] q_value
);

  logic [31:0]      hash_r, hash_nxt, hx;
  logic [KW*64-1:0] key_r, key_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic             nz;

  assign nz       = in_item.key_byte != 8'd0;
  assign in_ready = !(in_item.key_last && q_full);
  assign q_push   = in_valid && in_item.key_last && !q_full;
  assign hx       = hash_r ^ {24'd0, in_item.key_byte};

  always_comb begin
    hash_nxt = hash_r;
    key_nxt  = key_r;
    len_nxt  = len_r;
    if (nz) begin
      hash_nxt = hx * FNV_PRIME;
      if (len_r < LW'(KEY_BYTES))
        key_nxt[len_r*8 +: 8] = in_item.key_byte;
      if (len_r <= LW'(KEY_BYTES))
        len_nxt = len_r + LW'(1);
    end
  end

  assign q_hash     = hash_nxt;
  assign q_key      = key_nxt;
  assign q_too_long = len_nxt > LW'(KEY_BYTES);
  assign q_action   = in_item.action;
  assign q_value    = VALUE_BITS'(in_item.entry_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
      key_r  <= '0;
      len_r  <= '0;
    end else if (in_valid && in_ready) begin
      if (in_item.key_last) begin
        hash_r <= FNV_BASIS;
        key_r  <= '0;
        len_r  <= '0;
      end else begin
        hash_r <= hash_nxt;
        key_r  <= key_nxt;
        len_r  <= len_nxt;
      end
    end
  end

endmodule

>>> hdl/fnvlp_queue.sv
// ----------------------------------------------------------------------------
// fnvlp_queue
// Two-entry queue of finished keys between the front and the probe engine.
// ----------------------------------------------------------------------------
module fnvlp_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= !wp_r;
      if (pop && !empty) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

>>> hdl/fnvlp_back.sv
// ----------------------------------------------------------------------------
// fnvlp_back
// Probe engine: walks the table linearly and inserts or looks up one key.
// ----------------------------------------------------------------------------
module fnvlp_back import fnvlp_pkg::*; #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BYTES   = 32,
  parameter int VALUE_BITS  = 16,
  localparam int KW = (KEY_BYTES + 7) / 8,
  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
  localparam int CW = $clog2(TABLE_SLOTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [31:0]           k_hash,
  input  logic [KW*64-1:0]      k_key,
  input  logic                  k_too_long,
  input  logic                  k_action,
  input  logic [VALUE_BITS-1:0] k_value,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item
);

  bk_state_t        st_r, st_nxt;
  logic [TABLE_SLOTS-1:0] occ_r;
  logic [KW*64-1:0] skey_mem [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] sval_mem [TABLE_SLOTS];
  logic [KW*64-1:0] rkey_r;
  logic [VALUE_BITS-1:0] rval_r;
  logic [SW-1:0]    probe_r, probe_nxt;
  logic [CW-1:0]    steps_r, steps_nxt, count_r, count_nxt;
  logic             ovalid_r, ovalid_nxt;
  out_item_t        oitem_r, oitem_nxt;
  logic             wr_key, wr_val;
  logic [SW-1:0]    start;
  logic [63:0]      fv;

  assign out_empty = !ovalid_r;
  assign out_item  = oitem_r;
  assign start     = SW'(k_hash % TABLE_SLOTS);
  assign fv        = 64'(rval_r);

  always_ff @(posedge clk) begin
    rkey_r <= skey_mem[probe_r];
    rval_r <= sval_mem[probe_r];
    if (wr_key) skey_mem[probe_r] <= k_key;
    if (wr_val) sval_mem[probe_r] <= k_value;
  end

  always_comb begin
    st_nxt     = st_r;
    probe_nxt  = probe_r;
    steps_nxt  = steps_r;
    count_nxt  = count_r;
    ovalid_nxt = ovalid_r && !out_pop;
    oitem_nxt  = oitem_r;
    q_pop      = 1'b0;
    wr_key     = 1'b0;
    wr_val     = 1'b0;
    case (st_r)
      BK_IDLE: begin
        // A new key starts only once the previous result has been taken.
        if (!q_empty && !ovalid_r) begin
          if (k_too_long) begin
            oitem_nxt = '{ST_TOO_LONG, 16'd0, 6'd0, 7'(count_r)};
            st_nxt    = BK_DONE;
          end else begin
            probe_nxt = start;
            steps_nxt = '0;
            st_nxt    = BK_READ;
          end
        end
      end
      BK_READ: st_nxt = BK_CHECK;
      BK_CHECK: begin
        if (!occ_r[probe_r]) begin
          if (k_action) begin
            oitem_nxt = '{ST_NOT_FOUND, 16'd0, 6'd0, 7'(count_r)};
          end else begin
            wr_key    = 1'b1;
            wr_val    = 1'b1;
            count_nxt = count_r + CW'(1);
            oitem_nxt = '{ST_OK, 16'd0, 6'(probe_r), 7'(count_nxt)};
          end
          st_nxt = BK_DONE;
        end else if (rkey_r == k_key) begin
          if (k_action) begin
            oitem_nxt = '{ST_OK, fv[15:0], 6'(probe_r), 7'(count_r)};
          end else begin
            wr_val    = 1'b1;
            oitem_nxt = '{ST_REPLACED, 16'd0, 6'(probe_r), 7'(count_r)};
          end
          st_nxt = BK_DONE;
        end else if (steps_r == CW'(TABLE_SLOTS - 1)) begin
          oitem_nxt = '{(k_action ? ST_NOT_FOUND : ST_FULL), 16'd0, 6'd0, 7'(count_r)};
          st_nxt    = BK_DONE;
        end else begin
          probe_nxt = (probe_r == SW'(TABLE_SLOTS - 1)) ? '0 : probe_r + SW'(1);
          steps_nxt = steps_r + CW'(1);
          st_nxt    = BK_READ;
        end
      end
      BK_DONE: begin
        if (!ovalid_nxt) begin
          ovalid_nxt = 1'b1;
          q_pop      = 1'b1;
          st_nxt     = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= BK_IDLE;
      occ_r    <= '0;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
      if (wr_key) occ_r[probe_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    steps_r <= steps_nxt;
    oitem_r <= oitem_nxt;
  end

endmodule

>>> hdl/fnv1a_linear_probe_key_table.sv
// ----------------------------------------------------------------------------
// fnv1a_linear_probe_key_table
// Keyed table: FNV-1a hash of a byte-wise key, open addressing, linear probe.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake     Beat
// in_      input      push / full   one key byte with action and value
// out_     output     empty / pop   one status with value, slot and count
//
// A key byte that is not the last is taken every cycle; the hash is folded in
// the same cycle. The last byte enters a two-entry queue, and the probe engine
// then starts the walk from the hashed slot, visits each slot with a registered
// memory read and then the compare, and hands over the result; an overlong key
// skips the walk. The engine's single table port sets the rate. Reset is
// synchronous and clears the occupancy bits at once, so no clearing pass is
// needed. The front stalls only on a last byte when the queue is full; the
// engine stalls while an undelivered result waits.
module fnv1a_linear_probe_key_table import fnvlp_pkg::*; #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BYTES   = 32,
  parameter int VALUE_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  localparam int KW = (KEY_BYTES + 7) / 8;
  localparam int QW = 32 + KW * 64 + 2 + VALUE_BITS;

  logic                  f_ready, q_push, q_full, q_pop, q_empty;
  logic [31:0]           f_hash;
  logic [KW*64-1:0]      f_key;
  logic                  f_long, f_act;
  logic [VALUE_BITS-1:0] f_val;
  logic [QW-1:0]         q_rd;

  // The front holds off only a final byte when the queue has no room.
  assign in_full = !f_ready;

  fnvlp_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst_n, .in_valid(in_push), .in_item, .in_ready(f_ready),
    .q_push, .q_full, .q_hash(f_hash), .q_key(f_key), .q_too_long(f_long),
    .q_action(f_act), .q_value(f_val)
  );

  fnvlp_queue #(.W(QW)) u_queue (
    .clk, .rst_n, .push(q_push), .wdata({f_hash, f_key, f_long, f_act, f_val}),
    .full(q_full), .pop(q_pop), .rdata(q_rd), .empty(q_empty)
  );

  fnvlp_back #(
    .TABLE_SLOTS(TABLE_SLOTS), .KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk, .rst_n, .q_empty, .q_pop,
    .k_hash(q_rd[QW-1 -: 32]),
    .k_key(q_rd[VALUE_BITS+2 +: KW*64]),
    .k_too_long(q_rd[VALUE_BITS+1]),
    .k_action(q_rd[VALUE_BITS]),
    .k_value(q_rd[VALUE_BITS-1:0]),
    .out_empty, .out_pop, .out_item
  );

endmodule

>>> hdl/fnvlp_checker.sv
// ----------------------------------------------------------------------------
// fnvlp_checker
// Port-level checks on the key table, bound to the top level.
// ----------------------------------------------------------------------------
module fnvlp_checker import fnvlp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input in_item_t  in_item,
  input logic      in_full,
  input logic      out_pop,
  input logic      out_empty,
  input out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty == 1'b0 && !out_pop |=> out_empty == 1'b0 && $stable(out_item))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown after reset");

  a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> in_item.key_last)
    else $error("non-final byte stalled");

  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.status != ST_OK |-> out_item.found_value == 16'd0)
    else $error("value on failed operation");

endmodule

bind fnv1a_linear_probe_key_table fnvlp_checker u_chk (.*);

>>> test/tb_fnv1a_linear_probe_key_table.sv
// ----------------------------------------------------------------------------
// tb_fnv1a_linear_probe_key_table
// Self-checking bench for the FNV-1a keyed table with linear probing. Keys are
// sent byte by byte with random idling on both sides, a local model of the
// table predicts each status beat, and a scoreboard compares them in order.
// ----------------------------------------------------------------------------
module tb_fnv1a_linear_probe_key_table;
  import fnvlp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = 64;
  localparam int KEY_MAX   = 32;
  localparam int KEY_WORDS = KEY_MAX / 8;
  localparam int WATCHDOG  = 20000;

  // The scoreboard holds the predicted status beats in order of arrival and
  // compares every delivered beat, field by field, against the oldest one.
  class status_scoreboard;
    out_item_t pending[$];
    int        errors;
    int        checked;

    function void note_request(out_item_t predicted);
      pending.push_back(predicted);
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected status beat %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.found_value !== want.found_value) begin
        $display("%0t: found_value expected %h actual %h", $time, want.found_value,
                 got.found_value);
        errors++;
      end
      if (got.slot_index !== want.slot_index) begin
        $display("%0t: slot_index expected %0d actual %0d", $time, want.slot_index,
                 got.slot_index);
        errors++;
      end
      if (got.entry_total !== want.entry_total) begin
        $display("%0t: entry_total expected %0d actual %0d", $time, want.entry_total,
                 got.entry_total);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_item = '0;
  logic      in_full;
  logic      out_pop = 1'b0;
  logic      out_empty;
  out_item_t out_item;

  fnv1a_linear_probe_key_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_item(in_item), .in_full(in_full),
    .out_pop(out_pop), .out_empty(out_empty), .out_item(out_item)
  );

  always #4 clk = ~clk;

  // Model of the table as the bench sees it. The key being assembled lives in
  // the acc_ variables and is cleared after every final byte.
  logic [31:0] acc_hash;
  logic [63:0] acc_words [KEY_WORDS];
  int          acc_len;
  bit          tab_used  [SLOTS];
  logic [63:0] tab_words [SLOTS][KEY_WORDS];
  logic [15:0] tab_value [SLOTS];
  int          tab_count;

  status_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  int idle_run;
  int beats_sent;
  int keys_sent;
  int too_long_seen;
  int full_seen;
  int replaced_seen;
  bit timed_out;

  function automatic void clear_key();
    acc_hash = FNV_BASIS;
    for (int w = 0; w < KEY_WORDS; w++) acc_words[w] = '0;
    acc_len = 0;
  endfunction

  function automatic bit key_equal(int slot);
    for (int w = 0; w < KEY_WORDS; w++)
      if (tab_words[slot][w] != acc_words[w]) return 1'b0;
    return 1'b1;
  endfunction

  // Folds one byte into the pending key and, on a final byte, works out the
  // table operation. Returns 1 when a status beat is due.
  function automatic bit predict_table(in_item_t it, output out_item_t res);
    int start;
    int probe;
    res = '0;
    if (it.key_byte != 8'd0) begin
      acc_hash = (acc_hash ^ {24'd0, it.key_byte}) * FNV_PRIME;
      if (acc_len < KEY_MAX) acc_words[acc_len / 8][(acc_len % 8) * 8 +: 8] = it.key_byte;
      if (acc_len <= KEY_MAX) acc_len++;
    end
    if (!it.key_last) return 1'b0;
    if (acc_len > KEY_MAX) begin
      res.status = ST_TOO_LONG;
      res.entry_total = tab_count[6:0];
      too_long_seen++;
      clear_key();
      return 1'b1;
    end
    start = acc_hash % SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      probe = (start + i) % SLOTS;
      if (!tab_used[probe]) begin
        if (it.action) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int w = 0; w < KEY_WORDS; w++) tab_words[probe][w] = acc_words[w];
          tab_value[probe] = it.entry_value;
          tab_used[probe]  = 1'b1;
          tab_count++;
          res.status = ST_OK;
          res.slot_index = probe[5:0];
        end
        res.entry_total = tab_count[6:0];
        clear_key();
        return 1'b1;
      end
      if (key_equal(probe)) begin
        if (it.action) begin
          res.status = ST_OK;
          res.found_value = tab_value[probe];
        end else begin
          tab_value[probe] = it.entry_value;
          res.status = ST_REPLACED;
          replaced_seen++;
        end
        res.slot_index = probe[5:0];
        res.entry_total = tab_count[6:0];
        clear_key();
        return 1'b1;
      end
    end
    res.status = it.action ? ST_NOT_FOUND : ST_FULL;
    if (!it.action) full_seen++;
    res.entry_total = tab_count[6:0];
    clear_key();
    return 1'b1;
  endfunction

  // Offers one byte beat, idling first at the current rate, and holds it until
  // the block takes it. The prediction is made when the beat is accepted. The
  // push stays high afterwards so that beats can follow back to back; an idle
  // run or a drain drops it.
  task automatic send_byte(bit act, logic [7:0] b, bit last, logic [15:0] val);
    in_item_t  it;
    out_item_t res;
    if (idle_run == 0 && $urandom_range(99) < send_idle_pct) begin
      idle_run = $urandom_range(1, 6);
    end
    while (idle_run > 0) begin
      in_push <= 1'b0;
      @(posedge clk);
      idle_run--;
    end
    it.action = act;
    it.key_byte = b;
    it.key_last = last;
    it.entry_value = val;
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    if (predict_table(it, res)) board.note_request(res);
    beats_sent++;
    if (last) keys_sent++;
  endtask

  // Sends a whole key from an array of bytes; the value rides on every byte.
  task automatic send_key(bit act, logic [7:0] bytes[$], logic [15:0] val);
    for (int i = 0; i < bytes.size(); i++)
      send_byte(act, bytes[i], i == bytes.size() - 1, val);
    if (bytes.size() == 0) send_byte(act, 8'd0, 1'b1, val);
  endtask

  // Keys are drawn from a pool of short names so lookups and replaces hit.
  function automatic void pool_key(int idx, output logic [7:0] bytes[$]);
    bytes = {};
    bytes.push_back(8'h41 + idx[7:0] % 8'd26);
    if (idx >= 26) bytes.push_back(8'h61 + idx[7:0] / 8'd26);
    if (idx >= 52) bytes.push_back(8'hF0 ^ idx[7:0]);
  endfunction

  task automatic wait_drained();
    in_push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: pops at random according to the current idling rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) board.check_status(out_item);
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles with no beat accepted on either side.
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG && !timed_out) begin
        timed_out = 1'b1;
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] kb[$];
    int idx;
    board = new();
    clear_key();
    for (int s = 0; s < SLOTS; s++) tab_used[s] = 1'b0;
    tab_count = 0;
    send_idle_pct = 12;
    recv_idle_pct = 52;
    idle_run = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty key, lookup miss, insert, hit, replace, extremes of
    // value and byte, a zero byte inside a key, and keys just inside and past
    // the length limit.
    kb = {};
    send_key(1'b1, kb, 16'h0000);
    send_key(1'b0, kb, 16'hFFFF);
    send_key(1'b1, kb, 16'h1234);
    kb = {8'h01, 8'hFF};
    send_key(1'b1, kb, 16'h0);
    send_key(1'b0, kb, 16'hA5A5);
    send_key(1'b1, kb, 16'h0);
    send_key(1'b0, kb, 16'h5A5A);
    send_key(1'b1, kb, 16'h0);
    send_byte(1'b0, 8'h01, 1'b0, 16'h0);
    send_byte(1'b0, 8'h00, 1'b0, 16'h0);
    send_byte(1'b0, 8'hFF, 1'b0, 16'h0);
    send_byte(1'b1, 8'h00, 1'b1, 16'h0);
    kb = {};
    for (int i = 0; i < KEY_MAX; i++) kb.push_back(8'h80 + i[7:0]);
    send_key(1'b0, kb, 16'hBEEF);
    send_key(1'b1, kb, 16'h0);
    kb.push_back(8'h7F);
    send_key(1'b0, kb, 16'h1111);
    send_key(1'b1, kb, 16'h0);

    // The sender holds off until every predicted beat has been delivered.
    wait_drained();

    // Random part in three idling phases. Mostly pool keys so the table fills
    // and hits are common; some random keys, zero bytes and overlong keys.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 12 : 0;
      while (beats_sent < 300 * (phase + 1) + 40) begin
        idx = $urandom_range(99);
        kb = {};
        if (idx < 80) begin
          pool_key($urandom_range(0, 79), kb);
        end else if (idx < 95) begin
          repeat ($urandom_range(0, 6)) kb.push_back(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(KEY_MAX - 1, KEY_MAX + 3))
            kb.push_back(8'($urandom_range(1, 255)));
        end
        send_key(1'($urandom_range(1)), kb, 16'($urandom_range(0, 65535)));
      end
    end

    wait_drained();
    $display("Sent %0d byte beats in %0d keys; checked %0d status beats.",
             beats_sent, keys_sent, board.checked);
    $display("Covered %0d overlong keys, %0d full-table inserts, %0d replaces, %0d slots used.",
             too_long_seen, full_seen, replaced_seen, tab_count);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
